FILE: rtl/clr_pkg.sv
package clr_pkg;

  // canvas side limit and field widths
  localparam int MAX_SIDE_DEF = 256;
  localparam int COORD_W      = 8;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 9;
  localparam int OP_W         = 2;
  localparam int CFG_IDX_W    = 1;

  // opcodes
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  // fill byte for clear
  localparam logic [PIX_W-1:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [PIX_W-1:0]   pattern;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [PIX_W-1:0] pixel_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic rd_en;
    logic draw_step;
    logic clear_step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            draw_ok;
    logic            clear_empty;
    logic            draw_last;
    logic            clear_last;
  } dp_stat_t;

endpackage

FILE: rtl/clr_ctrl.sv
module clr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output clr_pkg::ctrl_cmd_t cmd,
  input  clr_pkg::dp_stat_t  stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DRAW  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        cmd.rd_en = 1'b1;
        if (stat.op == clr_pkg::OP_DRAW && stat.draw_ok) begin
          state_nxt = S_DRAW;
        end else if (stat.op == clr_pkg::OP_CLEAR && !stat.clear_empty) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        if (stat.draw_last) begin
          state_nxt = S_RESP;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an accepted beat always goes to setup
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SETUP))
    else $error("accepted beat did not enter setup");

  // last pixel of a line is followed by the result
  a_draw_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW && stat.draw_last) |=> out_valid)
    else $error("line finished without result");

endmodule

FILE: rtl/clr_dpath.sv
module clr_dpath #(
  parameter int MAX_SIDE = clr_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  clr_pkg::in_item_t               in_item,
  input  logic                            cfg_we,
  input  logic [clr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clr_pkg::CFG_W-1:0]       cfg_data,
  input  clr_pkg::ctrl_cmd_t              cmd,
  output clr_pkg::dp_stat_t               stat,
  output clr_pkg::out_item_t              out_item
);

  localparam int SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = 2 * SW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = clr_pkg::COORD_W;
  localparam int EW    = CW + 4;
  localparam logic [clr_pkg::CFG_W-1:0] SIDE_LIM = clr_pkg::CFG_W'(MAX_SIDE);

  // canvas size, clamped to the side limit on write
  logic [clr_pkg::CFG_W-1:0] width_r;
  logic [clr_pkg::CFG_W-1:0] height_r;
  logic [clr_pkg::CFG_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data > SIDE_LIM) ? SIDE_LIM : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clr_pkg::REG_WIDTH:  width_r  <= cfg_clamped;
        clr_pkg::REG_HEIGHT: height_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // latched command
  clr_pkg::in_item_t cmd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item;
    end
  end

  // bounds checks
  logic start_in;
  logic end_in;
  logic draw_ok;

  assign start_in = ({1'b0, cmd_r.start_x} < width_r) && ({1'b0, cmd_r.start_y} < height_r);
  assign end_in   = ({1'b0, cmd_r.end_x} < width_r) && ({1'b0, cmd_r.end_y} < height_r);
  assign draw_ok  = start_in && end_in;

  // line setup: deltas, major axis, walk start
  logic          x_fwd;
  logic          y_fwd;
  logic [CW-1:0] adx;
  logic [CW-1:0] ady;
  logic          major_x;
  logic [CW-1:0] mj0;
  logic [CW-1:0] mn0;
  logic          neg0;
  logic [CW-1:0] dmaj0;
  logic [CW-1:0] dmin0;

  always_comb begin
    x_fwd   = (cmd_r.end_x >= cmd_r.start_x);
    y_fwd   = (cmd_r.end_y >= cmd_r.start_y);
    adx     = x_fwd ? (cmd_r.end_x - cmd_r.start_x) : (cmd_r.start_x - cmd_r.end_x);
    ady     = y_fwd ? (cmd_r.end_y - cmd_r.start_y) : (cmd_r.start_y - cmd_r.end_y);
    major_x = (adx > ady);
    if (major_x) begin
      mj0   = x_fwd ? cmd_r.start_x : cmd_r.end_x;
      mn0   = x_fwd ? cmd_r.start_y : cmd_r.end_y;
      neg0  = x_fwd ? (cmd_r.end_y < cmd_r.start_y) : (cmd_r.end_y > cmd_r.start_y);
      dmaj0 = adx;
      dmin0 = ady;
    end else begin
      mj0   = y_fwd ? cmd_r.start_y : cmd_r.end_y;
      mn0   = y_fwd ? cmd_r.start_x : cmd_r.end_x;
      neg0  = y_fwd ? (cmd_r.end_x < cmd_r.start_x) : (cmd_r.end_x > cmd_r.start_x);
      dmaj0 = ady;
      dmin0 = adx;
    end
  end

  // walk registers
  logic                 maj_x_r;
  logic [CW-1:0]        mj_r;
  logic [CW-1:0]        mn_r;
  logic [CW-1:0]        cnt_r;
  logic signed [EW-1:0] err_r;
  logic [CW:0]          twod_r;
  logic [CW:0]          twoa_r;
  logic                 neg_r;

  logic signed [EW-1:0] err_add;
  logic signed [EW-1:0] twod_s;
  logic signed [EW-1:0] twoa_s;
  logic signed [EW-1:0] err_nxt;
  logic [CW-1:0]        mn_nxt;

  // error step: 2*k*dmin+D = off*2D+err, 0 <= err < 2D, signed off/dmin
  always_comb begin
    twod_s  = $signed({{(EW-CW-1){1'b0}}, twod_r});
    twoa_s  = $signed({{(EW-CW-1){1'b0}}, twoa_r});
    err_add = neg_r ? (err_r - twoa_s) : (err_r + twoa_s);
    err_nxt = err_add;
    mn_nxt  = mn_r;
    if (!neg_r && err_add >= twod_s) begin
      err_nxt = err_add - twod_s;
      mn_nxt  = mn_r + 1'b1;
    end else if (neg_r && err_add < 0) begin
      err_nxt = err_add + twod_s;
      mn_nxt  = mn_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      maj_x_r <= major_x;
      mj_r    <= mj0;
      mn_r    <= mn0;
      cnt_r   <= dmaj0;
      err_r   <= $signed({{(EW-CW){1'b0}}, dmaj0});
      twod_r  <= {dmaj0, 1'b0};
      twoa_r  <= {dmin0, 1'b0};
      neg_r   <= neg0;
    end else if (cmd.draw_step) begin
      mj_r    <= mj_r + 1'b1;
      mn_r    <= mn_nxt;
      cnt_r   <= cnt_r - 1'b1;
      err_r   <= err_nxt;
    end
  end

  // clear sweep counters
  logic [CW-1:0]             cx_r;
  logic [CW-1:0]             cy_r;
  logic                      cx_wrap;
  logic                      cy_wrap;

  assign cx_wrap = (({1'b0, cx_r} + 9'd1) == width_r);
  assign cy_wrap = (({1'b0, cy_r} + 9'd1) == height_r);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cmd.clear_step) begin
      if (cx_wrap) begin
        cx_r <= '0;
        cy_r <= cy_r + 1'b1;
      end else begin
        cx_r <= cx_r + 1'b1;
      end
    end
  end

  // canvas memory, address is {row, column}
  logic [clr_pkg::PIX_W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]             mem_addr;
  logic [clr_pkg::PIX_W-1:0] mem_wdata;
  logic                      mem_we;
  logic [clr_pkg::PIX_W-1:0] rd_data_r;

  always_comb begin
    mem_we    = cmd.clear_step || cmd.draw_step;
    mem_wdata = cmd.clear_step ? clr_pkg::SPACE_CHAR : cmd_r.pattern;
    priority if (cmd.clear_step) begin
      mem_addr = {cy_r[SW-1:0], cx_r[SW-1:0]};
    end else if (cmd.draw_step) begin
      mem_addr = maj_x_r ? {mn_r[SW-1:0], mj_r[SW-1:0]} : {mj_r[SW-1:0], mn_r[SW-1:0]};
    end else begin
      mem_addr = {cmd_r.start_y[SW-1:0], cmd_r.start_x[SW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // result registers
  logic status_r;
  logic pix_sel_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      status_r  <= ((cmd_r.opcode == clr_pkg::OP_DRAW) && !draw_ok) ||
                   ((cmd_r.opcode == clr_pkg::OP_READ) && !start_in);
      pix_sel_r <= (cmd_r.opcode == clr_pkg::OP_READ) && start_in;
    end
  end

  assign out_item.status      = status_r;
  assign out_item.pixel_value = pix_sel_r ? rd_data_r : '0;

  // status to controller
  assign stat.op          = cmd_r.opcode;
  assign stat.draw_ok     = draw_ok;
  assign stat.clear_empty = (width_r == '0) || (height_r == '0);
  assign stat.draw_last   = (cnt_r == '0);
  assign stat.clear_last  = cx_wrap && cy_wrap;

  // every line pixel lies inside the canvas
  a_draw_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_step |-> (maj_x_r ?
      (({1'b0, mj_r} < width_r) && ({1'b0, mn_r} < height_r)) :
      (({1'b0, mn_r} < width_r) && ({1'b0, mj_r} < height_r))))
    else $error("line pixel outside canvas");

  // clear sweep stays inside the region
  a_clear_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> (({1'b0, cx_r} < width_r) && ({1'b0, cy_r} < height_r)))
    else $error("clear sweep outside canvas");

endmodule

FILE: rtl/canvas_line_rasterizer.sv
// read, error and other commands: accept, setup, then the result strobe;
// draw then walks the line, one pixel written per cycle along the longer axis;
// clear then sweeps W*H pixels, one per cycle through the single canvas port.
// throughput: next start taken the cycle after the result strobe.
// reset: synchronous active low, clears control state and canvas size to 0;
// canvas contents are undefined until written. results cannot be stalled.
module canvas_line_rasterizer #(
  parameter int MAX_SIDE = clr_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  clr_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output clr_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clr_pkg::CFG_W-1:0]     cfg_data
);

  clr_pkg::ctrl_cmd_t cmd;
  clr_pkg::dp_stat_t  stat;

  // configuration beats are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // line walker, clear sweep and canvas memory
  clr_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule
